[hdl/method_argument_transfer_macros.svh]
// Assertion macros shared by the method argument transfer RTL.
`ifndef METHOD_ARGUMENT_TRANSFER_MACROS_SVH
`define METHOD_ARGUMENT_TRANSFER_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on an explicit clock and active-low reset
`define MAT_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the block clock and reset
`define MAT_ASSERT(lbl, prop, msg) `MAT_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`else

`define MAT_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define MAT_ASSERT(lbl, prop, msg)

`endif

`endif

[hdl/mat_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mat_pkg;

  // Request commands
  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_CHAR  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Entry type tags
  localparam logic [2:0] TAG_INT    = 3'd0;
  localparam logic [2:0] TAG_FLOAT  = 3'd1;
  localparam logic [2:0] TAG_LONG   = 3'd2;
  localparam logic [2:0] TAG_DOUBLE = 3'd3;
  localparam logic [2:0] TAG_OBJECT = 3'd4;

  // Result status codes
  localparam logic [3:0] ST_ACCEPTED = 4'd0;
  localparam logic [3:0] ST_STORED   = 4'd1;
  localparam logic [3:0] ST_COMPLETE = 4'd2;
  localparam logic [3:0] ST_OVERFLOW = 4'd3;
  localparam logic [3:0] ST_UNDERFLOW = 4'd4;
  localparam logic [3:0] ST_MISMATCH = 4'd5;
  localparam logic [3:0] ST_SLOT_RANGE = 4'd6;
  localparam logic [3:0] ST_NO_PAREN = 4'd7;
  localparam logic [3:0] ST_BAD_TYPE = 4'd8;
  localparam logic [3:0] ST_UNTERM   = 4'd9;
  localparam logic [3:0] ST_EXTRA    = 4'd10;
  localparam logic [3:0] ST_IGNORED  = 4'd11;

  // Configuration register indexes
  localparam logic CFG_STACK_LIMIT = 1'b0;
  localparam logic CFG_LOCAL_LIMIT = 1'b1;

  // Descriptor characters
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_LPAREN   = 8'h28;
  localparam logic [7:0] CH_RPAREN   = 8'h29;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_L        = 8'h4C;
  localparam logic [7:0] CH_D        = 8'h44;
  localparam logic [7:0] CH_J        = 8'h4A;
  localparam logic [7:0] CH_F        = 8'h46;
  localparam logic [7:0] CH_B        = 8'h42;
  localparam logic [7:0] CH_C        = 8'h43;
  localparam logic [7:0] CH_I        = 8'h49;
  localparam logic [7:0] CH_S        = 8'h53;
  localparam logic [7:0] CH_Z        = 8'h5A;

  // One operand stack entry
  typedef struct packed {
    logic [2:0]  tag;
    logic [63:0] value;
  } entry_t;

  // Shift command for the row of stack cells
  typedef struct packed {
    logic push;
    logic pop;
  } stack_op_t;

  // One result item
  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] slot;
    logic [2:0]  tag;
    logic [63:0] value;
    logic        wide;
  } result_t;

endpackage

`default_nettype wire

[hdl/mat_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module mat_cell
  import mat_pkg::*;
(
  input  wire logic      clk_i,
  input  wire stack_op_t op_i,
  input  wire entry_t    above_i,
  input  wire entry_t    below_i,
  output entry_t         entry_o
);

  entry_t entry_q;
  entry_t entry_d;

  // Take the upper neighbor on push, the lower neighbor on pop, else hold
  always_comb begin
    entry_d = entry_q;
    if (op_i.push) begin
      entry_d = above_i;
    end else if (op_i.pop) begin
      entry_d = below_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

[hdl/mat_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "method_argument_transfer_macros.svh"

module mat_ctrl
  import mat_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        req_i,
  input  wire logic [1:0]  command_i,
  input  wire logic [7:0]  character_i,
  input  wire entry_t      top_i,
  input  wire logic [6:0]  stack_limit_i,
  input  wire logic [15:0] local_limit_i,
  output stack_op_t        op_o,
  output result_t          res_o
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;

  // Parse phases
  localparam logic [2:0] PH_PAREN = 3'd0;
  localparam logic [2:0] PH_ARGS  = 3'd1;
  localparam logic [2:0] PH_OBJ   = 3'd2;
  localparam logic [2:0] PH_DONE  = 3'd3;
  localparam logic [2:0] PH_ERR   = 3'd4;

  logic [2:0]       phase_q, phase_d;
  logic             arr_q, arr_d;
  logic [16:0]      slot_q, slot_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic       full;
  logic       take;
  logic [2:0] exp_tag;
  logic       exp_wide;

  // Room check against both the limit register and the physical depth
  assign full = (CMP_W'(cnt_q) >= CMP_W'(stack_limit_i)) ||
                (cnt_q >= CNT_W'(STACK_DEPTH));

  // Decode one request and compute the next parse state
  always_comb begin
    phase_d  = phase_q;
    arr_d    = arr_q;
    slot_d   = slot_q;
    cnt_d    = cnt_q;
    op_o     = '0;
    res_o    = '0;
    take     = 1'b0;
    exp_tag  = TAG_INT;
    exp_wide = 1'b0;

    if (req_i) begin
      if (command_i == CMD_CLEAR) begin
        cnt_d   = '0;
        phase_d = PH_PAREN;
        arr_d   = 1'b0;
        slot_d  = '0;
      end else if ((command_i != CMD_PUSH && command_i != CMD_CHAR) ||
                   phase_q == PH_ERR) begin
        res_o.status = ST_IGNORED;
      end else if (command_i == CMD_PUSH) begin
        if (full) begin
          res_o.status = ST_OVERFLOW;
          phase_d      = PH_ERR;
        end else begin
          op_o.push = 1'b1;
          cnt_d     = cnt_q + 1'b1;
        end
      end else begin
        case (phase_q)
          PH_PAREN: begin
            if (character_i == CH_LPAREN) begin
              phase_d = PH_ARGS;
            end else begin
              res_o.status = ST_NO_PAREN;
              phase_d      = PH_ERR;
            end
          end
          PH_ARGS: begin
            case (character_i)
              CH_LBRACKET: arr_d = 1'b1;
              CH_RPAREN: begin
                if (arr_q) begin
                  res_o.status = ST_BAD_TYPE;
                  phase_d      = PH_ERR;
                end else if (cnt_q != '0) begin
                  res_o.status = ST_EXTRA;
                  phase_d      = PH_ERR;
                end else begin
                  res_o.status = ST_COMPLETE;
                  phase_d      = PH_DONE;
                end
              end
              CH_L: phase_d = PH_OBJ;
              CH_D: begin
                take     = 1'b1;
                exp_tag  = TAG_DOUBLE;
                exp_wide = 1'b1;
              end
              CH_J: begin
                take     = 1'b1;
                exp_tag  = TAG_LONG;
                exp_wide = 1'b1;
              end
              CH_F: begin
                take    = 1'b1;
                exp_tag = TAG_FLOAT;
              end
              CH_B, CH_C, CH_I, CH_S, CH_Z: begin
                take    = 1'b1;
                exp_tag = TAG_INT;
              end
              default: begin
                res_o.status = ST_BAD_TYPE;
                phase_d      = PH_ERR;
              end
            endcase
          end
          PH_OBJ: begin
            if (character_i == CH_SEMI) begin
              take    = 1'b1;
              exp_tag = TAG_OBJECT;
            end else if (character_i == CH_NUL) begin
              res_o.status = ST_UNTERM;
              phase_d      = PH_ERR;
            end
          end
          default: res_o.status = ST_IGNORED;
        endcase

        // Pop the top entry as an argument and check it, or flag underflow on an empty stack
        if (take) begin
          if (arr_q) begin
            exp_tag  = TAG_OBJECT;
            exp_wide = 1'b0;
          end
          arr_d = 1'b0;
          if (cnt_q == '0) begin
            res_o.status = ST_UNDERFLOW;
            phase_d      = PH_ERR;
          end else begin
            op_o.pop = 1'b1;
            cnt_d    = cnt_q - 1'b1;
            if (top_i.tag != exp_tag) begin
              res_o.status = ST_MISMATCH;
              phase_d      = PH_ERR;
            end else if (slot_q >= {1'b0, local_limit_i}) begin
              res_o.status = ST_SLOT_RANGE;
              phase_d      = PH_ERR;
            end else begin
              res_o.status = ST_STORED;
              res_o.slot   = slot_q[15:0];
              res_o.tag    = top_i.tag;
              res_o.value  = top_i.value;
              res_o.wide   = exp_wide;
              slot_d       = slot_q + (exp_wide ? 17'd2 : 17'd1);
              phase_d      = PH_ARGS;
            end
          end
        end
      end
    end
  end

  // Hold parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PAREN;
      arr_q   <= 1'b0;
      slot_q  <= '0;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      arr_q   <= arr_d;
      slot_q  <= slot_d;
      cnt_q   <= cnt_d;
    end
  end

  `MAT_ASSERT(a_err_latched, (req_i && phase_q == PH_ERR && command_i != CMD_CLEAR) |-> (res_o.status == ST_IGNORED), "request after error not ignored")
  `MAT_ASSERT(a_stored_pops, (res_o.status == ST_STORED) |-> (op_o.pop && !op_o.push), "argument stored without a pop")
  `MAT_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(STACK_DEPTH), "stack count beyond depth")

endmodule

`default_nettype wire

[hdl/method_argument_transfer.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "method_argument_transfer_macros.svh"

// Method argument transfer. Push requests fill a typed operand stack, and
// descriptor character requests walk a method descriptor, popping one stack
// entry per argument and returning it with its callee local slot. Every
// request yields exactly one result. One request is accepted per clock
// while the skid register is empty; its result is registered in the
// output register, or in the skid register on a stall. The stack is a
// row of STACK_DEPTH cells that all shift one place on a push or a pop,
// so the top entry is always in the first cell. A two-entry output stage
// (result register plus skid register) keeps accepting one request while
// the output is stalled. There is no clearing pass after reset.
module method_argument_transfer
  import mat_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [2:0]  entry_type_i,
  input  wire logic [63:0] entry_value_i,
  input  wire logic [7:0]  character_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       status_o,
  output logic [15:0]      slot_index_o,
  output logic [2:0]       arg_type_o,
  output logic [63:0]      arg_value_o,
  output logic             wide_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  logic [6:0]  stack_limit_q, stack_limit_d;
  logic [15:0] local_limit_q, local_limit_d;

  logic      in_fire;
  logic      out_fire;
  stack_op_t op;
  result_t   res;
  entry_t    push_entry;
  entry_t    cells [STACK_DEPTH];

  result_t out_data_q, out_data_d;
  result_t skid_data_q, skid_data_d;
  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;

  // Write configuration registers
  always_comb begin
    stack_limit_d = stack_limit_q;
    local_limit_d = local_limit_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_STACK_LIMIT: stack_limit_d = cfg_data_i[6:0];
        CFG_LOCAL_LIMIT: local_limit_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_limit_q <= 7'd64;
      local_limit_q <= 16'hFFFF;
    end else begin
      stack_limit_q <= stack_limit_d;
      local_limit_q <= local_limit_d;
    end
  end

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;

  // Parse control
  mat_ctrl #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (in_fire),
    .command_i     (command_i),
    .character_i   (character_i),
    .top_i         (cells[0]),
    .stack_limit_i (stack_limit_q),
    .local_limit_i (local_limit_q),
    .op_o          (op),
    .res_o         (res)
  );

  assign push_entry.tag   = entry_type_i;
  assign push_entry.value = entry_value_i;

  // Row of stack cells, top of stack in cell zero
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    entry_t above;
    entry_t below;
    if (i == 0) begin : g_first
      assign above = push_entry;
    end else begin : g_mid
      assign above = cells[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign below = cells[i];
    end else begin : g_inner
      assign below = cells[i+1];
    end
    mat_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (op),
      .above_i (above),
      .below_i (below),
      .entry_o (cells[i])
    );
  end

  // Steer results into the output register or the skid register
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        out_data_d  = res;
        out_valid_d = 1'b1;
      end else begin
        skid_data_d  = res;
        skid_valid_d = 1'b1;
      end
    end else if (out_fire) begin
      if (skid_valid_q) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_data_q.status;
  assign slot_index_o = out_data_q.slot;
  assign arg_type_o   = out_data_q.tag;
  assign arg_value_o  = out_data_q.value;
  assign wide_o       = out_data_q.wide;

  `MAT_ASSERT(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid holds a result with output empty")
  `MAT_ASSERT(a_stall_to_skid, (in_fire && out_valid_q && !out_ready_i) |=> skid_valid_q, "stalled result not kept in skid")
  `MAT_ASSERT(a_out_hold, (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_data_q)), "stalled result changed before acceptance")

endmodule

`default_nettype wire
